@@ rtl/tjq_pkg.sv @@
// Package for the traffic jam qualifier: sizes, register map, config and stage types.
`default_nettype none
package tjq_pkg;

    localparam int WINDOW     = 100;
    localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int OUT_CNT_W  = 7;
    localparam int HOLD_W     = 15;
    localparam int ADDR_W     = 5;
    localparam int NUM_REGS   = 5;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 16;

    localparam logic [7:0]        NO_TARGET_ID = 8'd255;
    localparam logic [HOLD_W-1:0] HOLD_MAX     = {HOLD_W{1'b1}};

    typedef enum logic [2:0] {
        REG_SPEED_LIMIT    = 3'd0,
        REG_FRONT_DIST     = 3'd1,
        REG_OCC_THRESHOLD  = 3'd2,
        REG_STEER_LIMIT    = 3'd3,
        REG_STEER_HOLD     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [14:0] speed_limit;
        logic [14:0] front_distance_limit;
        logic [6:0]  occupancy_threshold;
        logic [14:0] steer_limit;
        logic [13:0] steer_hold_ticks;
    } cfg_t;

    // Per-item flags carried from the decode stage into the state update stage.
    typedef struct packed {
        logic slow;
        logic present;
        logic steer_hit;
    } item_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] window_ones;
        logic                 just_steered;
        logic                 persistent;
    } upd_res_t;

endpackage
`default_nettype wire

@@ rtl/traffic_jam_qualifier.sv @@
// Traffic jam qualifier: each request is one tick, registered in the update stage, then the output.
// Throughput is one request per cycle unless the result stalls, set by the window memory's single read-first port.
// The window memory is never swept: slots read before the pointer first wraps count as zero.
// Reset is synchronous and active low; it restores the registers and clears count and hold.
// A stalled result does not block input while the update stage is free or draining.
`default_nettype none
module traffic_jam_qualifier
    import tjq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // speed[15:0], target_id[23:16], target_distance[39:24], steer_angle[55:40]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // slow_speed[0], front_present[1], front_persistent[2], just_steered[3],
    // window_ones[10:4], zero[15:11]
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    cfg_t     cfg;
    item_t    item_in;
    item_t    s1_item_reg;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    logic     m_valid_reg;
    logic     m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic     accept;
    logic     advance;
    logic     old_bit;
    upd_res_t res;

    logic signed [15:0] speed;
    logic        [7:0]  target_id;
    logic signed [15:0] distance;
    logic signed [15:0] angle;
    logic        [16:0] angle_mag;

    tjq_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign speed     = s_tdata[15:0];
    assign target_id = s_tdata[23:16];
    assign distance  = s_tdata[39:24];
    assign angle     = s_tdata[55:40];
    assign angle_mag = angle[15] ? 17'(-{angle[15], angle}) : {1'b0, angle};

    always_comb begin
        item_in.slow      = ($signed({speed[15], speed}) <= $signed({2'b00, cfg.speed_limit}));
        item_in.present   = (target_id != NO_TARGET_ID) &&
                            ($signed({distance[15], distance}) <
                             $signed({2'b00, cfg.front_distance_limit}));
        item_in.steer_hit = (angle_mag > {2'b00, cfg.steer_limit});
    end

    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    tjq_window_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept),
        .wr_bit  (item_in.present),
        .old_bit (old_bit)
    );

    tjq_state_update u_upd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (s1_item_reg),
        .old_bit (old_bit),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= item_in;
        end
        if (advance) begin
            m_data_reg <= {5'd0, res.window_ones, res.just_steered, res.persistent,
                           s1_item_reg.present, s1_item_reg.slow};
        end
    end

    assign m_tdata  = m_data_reg;
    assign m_tvalid = m_valid_reg;

    // Input must not be taken while the update stage holds an item that the output cannot take.
    a_no_input_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while update stage is blocked");

    // An unsaturated count must agree with the persistence flag.
    a_persist_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg[10:4] != 7'd127) |->
            m_data_reg[2] == (m_data_reg[10:4] > cfg.occupancy_threshold))
        else $error("front_persistent disagrees with window_ones");

    // The window count can never exceed the window length.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ({1'b0, m_data_reg[10:4]} <= 8'(WINDOW > 127 ? 127 : WINDOW)))
        else $error("window_ones exceeds window length");

    // A strong steer with a nonzero hold must show just_steered on its result.
    a_steer_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && s1_item_reg.steer_hit && (cfg.steer_hold_ticks != 14'd0)
            |=> m_data_reg[3])
        else $error("strong steer did not raise just_steered");

endmodule
`default_nettype wire

@@ rtl/tjq_cfg_regs.sv @@
// APB register file holding the qualifier thresholds.
`default_nettype none
module tjq_cfg_regs
    import tjq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_limit          <= 15'd830;
            cfg_reg.front_distance_limit <= 15'd3000;
            cfg_reg.occupancy_threshold  <= 7'd80;
            cfg_reg.steer_limit          <= 15'd1500;
            cfg_reg.steer_hold_ticks     <= 14'd500;
        end else if (wr_en) begin
            case (idx)
                REG_SPEED_LIMIT:   cfg_reg.speed_limit          <= pwdata[14:0];
                REG_FRONT_DIST:    cfg_reg.front_distance_limit <= pwdata[14:0];
                REG_OCC_THRESHOLD: cfg_reg.occupancy_threshold  <= pwdata[6:0];
                REG_STEER_LIMIT:   cfg_reg.steer_limit          <= pwdata[14:0];
                REG_STEER_HOLD:    cfg_reg.steer_hold_ticks     <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SPEED_LIMIT:   prdata = {17'd0, cfg_reg.speed_limit};
            REG_FRONT_DIST:    prdata = {17'd0, cfg_reg.front_distance_limit};
            REG_OCC_THRESHOLD: prdata = {25'd0, cfg_reg.occupancy_threshold};
            REG_STEER_LIMIT:   prdata = {17'd0, cfg_reg.steer_limit};
            REG_STEER_HOLD:    prdata = {18'd0, cfg_reg.steer_hold_ticks};
            default:           prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/tjq_window_mem.sv @@
// Circular presence window memory with a read-first port and its slot pointer.
`default_nettype none
module tjq_window_mem
    import tjq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_en,
    input  wire logic wr_bit,
    output logic      old_bit
);

    logic             mem [WINDOW];
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic             wrapped_reg;
    logic             wrapped_next;
    logic             rd_bit_reg;
    logic             rd_valid_reg;
    logic             at_end;

    assign at_end = (ptr_reg == PTR_W'(WINDOW - 1));

    always_comb begin
        ptr_next     = ptr_reg;
        wrapped_next = wrapped_reg;
        if (wr_en) begin
            ptr_next = at_end ? '0 : ptr_reg + PTR_W'(1);
            if (at_end) begin
                wrapped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // The pointer walks the slots in order, so before the first wrap every
    // slot read has never been written and counts as zero through the wrapped flag.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rd_bit_reg   <= mem[ptr_reg];
            rd_valid_reg <= wrapped_reg;
            mem[ptr_reg] <= wr_bit;
        end
    end

    assign old_bit = rd_bit_reg && rd_valid_reg;

endmodule
`default_nettype wire

@@ rtl/tjq_state_update.sv @@
// Running ones count and steering hold state, updated once per item.
`default_nettype none
module tjq_state_update
    import tjq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic advance,
    input  item_t     item,
    input  wire logic old_bit,
    input  cfg_t      cfg,
    output upd_res_t  res
);

    logic [CNT_W-1:0]  ones_reg;
    logic [CNT_W-1:0]  ones_next;
    logic [CNT_W-1:0]  ones_dec;
    logic              flag_reg;
    logic              flag_next;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;

    always_comb begin
        ones_dec  = (old_bit && (ones_reg != '0)) ? ones_reg - CNT_W'(1) : ones_reg;
        ones_next = ones_dec + CNT_W'(item.present);

        flag_next = flag_reg;
        hold_next = hold_reg;
        if (item.steer_hit) begin
            flag_next = 1'b1;
            hold_next = '0;
        end
        if (flag_next) begin
            if (hold_next != HOLD_MAX) begin
                hold_next = hold_next + HOLD_W'(1);
            end
            if (hold_next > HOLD_W'(cfg.steer_hold_ticks)) begin
                flag_next = 1'b0;
            end
        end

        res.persistent   = (ones_next > CNT_W'(cfg.occupancy_threshold));
        res.just_steered = flag_next;
        if (ones_next > CNT_W'(127)) begin
            res.window_ones = 7'd127;
        end else begin
            res.window_ones = OUT_CNT_W'(ones_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ones_reg <= '0;
            flag_reg <= 1'b0;
            hold_reg <= '0;
        end else if (advance) begin
            ones_reg <= ones_next;
            flag_reg <= flag_next;
            hold_reg <= hold_next;
        end
    end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the traffic jam qualifier: stream stimulus, APB setup, scoreboard.
`default_nettype none
module tb;
    import tjq_pkg::*;

    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] distance;
        logic [7:0]         target_id;
        logic signed [15:0] speed;
    } tick_t;

    typedef struct packed {
        logic [4:0] pad;
        logic [6:0] ones;
        logic       steered;
        logic       persistent;
        logic       present;
        logic       slow;
    } flags_t;

    class tjq_scoreboard;
        int unsigned limit_val[NUM_REGS];
        int unsigned reg_bits[NUM_REGS];
        bit          presence[WINDOW];
        int          slot;
        int          ones;
        bit          steering;
        int          hold;
        flags_t      due[$];
        int          errors;

        function new();
            reg_bits  = '{15, 15, 7, 15, 14};
            limit_val = '{830, 3000, 80, 1500, 500};
            foreach (presence[i]) presence[i] = 1'b0;
            slot = 0;
            ones = 0;
            steering = 1'b0;
            hold = 0;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, int unsigned value);
            limit_val[idx] = value & ((32'd1 << reg_bits[idx]) - 1);
        endfunction

        function void report(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endfunction

        // Works out the flags that one accepted tick must produce.
        function void note_tick(tick_t t);
            flags_t f;
            int     spd;
            int     gap;
            int     ang;
            int     mag;
            spd  = $signed(t.speed);
            gap  = $signed(t.distance);
            ang  = $signed(t.angle);
            f = '0;
            f.slow    = spd <= int'(limit_val[REG_SPEED_LIMIT]);
            f.present = (t.target_id != NO_TARGET_ID) &&
                        (gap < int'(limit_val[REG_FRONT_DIST]));
            if (presence[slot]) ones--;
            presence[slot] = f.present;
            ones += f.present;
            slot = (slot + 1) % WINDOW;
            f.persistent = ones > int'(limit_val[REG_OCC_THRESHOLD]);
            mag = (ang < 0) ? -ang : ang;
            if (mag > int'(limit_val[REG_STEER_LIMIT])) begin
                steering = 1'b1;
                hold = 0;
            end
            if (steering) begin
                if (hold < int'(HOLD_MAX)) hold++;
                if (hold > int'(limit_val[REG_STEER_HOLD])) steering = 1'b0;
            end
            f.steered = steering;
            f.ones = (ones > 127) ? 7'd127 : 7'(ones);
            due.push_back(f);
        endfunction

        function void field_check(string name, int got, int want);
            if (got != want) report($sformatf("%s: got %0d, expected %0d", name, got, want));
        endfunction

        function void check_flags(flags_t got);
            flags_t want;
            if (due.size() == 0) begin
                report($sformatf("result %h arrived with nothing due", got));
                return;
            end
            want = due.pop_front();
            field_check("slow_speed", got.slow, want.slow);
            field_check("front_present", got.present, want.present);
            field_check("front_persistent", got.persistent, want.persistent);
            field_check("just_steered", got.steered, want.steered);
            field_check("window_ones", got.ones, want.ones);
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void drain_check();
            if (due.size() != 0) report($sformatf("%0d results never arrived", due.size()));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tvalid;
    wire logic           s_tready;
    wire logic [M_DATA_W-1:0] m_tdata;
    wire logic           m_tvalid;
    logic                m_tready;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    wire logic [31:0]    prdata;
    wire logic           pready;

    tjq_scoreboard sb = new();
    bit            calm;
    int            stall_left;
    int            quiet_cycles;

    traffic_jam_qualifier DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Result side: random stall bursts, none once calm.
    always @(negedge aclk) begin
        if (calm) begin
            m_tready = 1'b1;
        end else if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            m_tready = 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            m_tready = 1'b1;
        end
    end

    // Results are checked before the same edge's request is noted; no result leaves in the cycle its request is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_flags(m_tdata);
            if (s_tvalid && s_tready) sb.note_tick(s_tdata);
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic tick_t mk(int spd, int id, int gap, int ang);
        tick_t t;
        t.speed     = 16'(spd);
        t.target_id = 8'(id);
        t.distance  = 16'(gap);
        t.angle     = 16'(ang);
        return t;
    endfunction

    function automatic tick_t random_tick(int pct_present, int pct_steer);
        tick_t t;
        int    lim_s;
        int    lim_d;
        int    lim_a;
        int    mag;
        lim_s = sb.limit_val[REG_SPEED_LIMIT];
        lim_d = sb.limit_val[REG_FRONT_DIST];
        lim_a = sb.limit_val[REG_STEER_LIMIT];
        case ($urandom_range(0, 3))
            0: t.speed = 16'($urandom);
            1: t.speed = 16'(lim_s + int'($urandom_range(0, 4)) - 2);
            2: t.speed = 16'(-int'($urandom_range(1, 32768)));
            default: t.speed = 16'($urandom_range(0, 2000));
        endcase
        if ($urandom_range(0, 99) < pct_present) begin
            t.target_id = 8'($urandom_range(0, 254));
            if ($urandom_range(0, 1))
                t.distance = 16'(lim_d - 1 - int'($urandom_range(0, 3)));
            else
                t.distance = 16'(int'($urandom_range(0, lim_d + 32767)) - 32768);
        end else if ($urandom_range(0, 1)) begin
            t.target_id = NO_TARGET_ID;
            t.distance  = 16'($urandom);
        end else begin
            t.target_id = 8'($urandom_range(0, 254));
            t.distance  = 16'(lim_d + int'($urandom_range(0, 32767 - lim_d)));
        end
        // A magnitude of 32768 wraps to the most negative angle.
        if ($urandom_range(0, 99) < pct_steer)
            mag = $urandom_range(lim_a + 1, 32768);
        else
            mag = $urandom_range(0, lim_a);
        t.angle = 16'($urandom_range(0, 1) ? -mag : mag);
        return t;
    endfunction

    // Called at a falling edge; returns at a falling edge with s_tvalid low.
    task automatic send_tick(tick_t t);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tdata  = t;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic run_random(int count, int pct_present, int pct_steer);
        repeat (count) send_tick(random_tick(pct_present, pct_steer));
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned value);
        int unsigned junk;
        junk = $urandom_range(0, 1) ? ($urandom << sb.reg_bits[idx]) : 0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(4 * idx);
        pwdata  = value | junk;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.set_reg(idx, value | junk);
    endtask

    task automatic write_all(int unsigned spd, int unsigned gap, int unsigned occ,
                             int unsigned ang, int unsigned hold_ticks);
        write_reg(REG_SPEED_LIMIT, spd);
        write_reg(REG_FRONT_DIST, gap);
        write_reg(REG_OCC_THRESHOLD, occ);
        write_reg(REG_STEER_LIMIT, ang);
        write_reg(REG_STEER_HOLD, hold_ticks);
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_tdata    = '0;
        s_tvalid   = 1'b0;
        m_tready   = 1'b1;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        calm       = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Reset limits: speed 8.30 m/s, distance 30.00 m, steer 150.0 degrees.
        send_tick(mk(-32768, 0, -32768, -32768));
        send_tick(mk(32767, 255, -5, 32767));
        send_tick(mk(830, 254, 2999, 1500));
        send_tick(mk(831, 254, 3000, 1501));
        send_tick(mk(0, 255, 32767, -1501));
        send_tick(mk(-1, 1, 0, -1500));
        send_tick(mk(829, 128, 32767, 0));
        send_tick(mk(32767, 0, 2999, -32767));
        send_tick(mk(-32768, 255, -32768, 1));
        send_tick(mk(500, 255, 100, -1));
        repeat (10) send_tick(mk(100, 7, 500, 20));
        run_random(150, 90, 2);
        settle();

        // All limits at zero: a zero hold clears the steer flag in the same tick.
        write_all(0, 0, 0, 0, 0);
        send_tick(mk(0, 3, -1, 1));
        send_tick(mk(1, 3, 0, 0));
        run_random(120, 50, 30);
        settle();

        write_all(32767, 32767, 100, 32767, 16383);
        run_random(120, 95, 3);
        settle();

        write_all($urandom_range(0, 3000), $urandom_range(0, 6000), $urandom_range(1, 40),
                  $urandom_range(100, 3000), $urandom_range(0, 40));
        run_random(150, 40, 10);
        settle();

        calm = 1'b1;
        write_all($urandom_range(0, 3000), $urandom_range(0, 6000), $urandom_range(0, 100),
                  $urandom_range(100, 3000), $urandom_range(0, 60));
        run_random(150, 60, 8);
        settle();
        repeat (6) @(posedge aclk);

        sb.drain_check();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
